[sv/topt_pkg.sv]
// Shared types, codes and default sizes for the 2-opt first-improvement block.
package topt_pkg;

  localparam int unsigned MAX_VERTICES_DEF = 64;
  localparam int unsigned COST_BITS_DEF    = 32;
  localparam int unsigned TOTAL_W          = 38;
  localparam int unsigned VID_W            = 6;
  localparam int unsigned NUM_W            = 7;
  localparam logic [NUM_W-1:0] NUM_VERTICES_RESET = 7'd64;
  localparam logic [NUM_W-1:0] NUM_VERTICES_MIN   = 7'd3;

  typedef enum logic [1:0] {
    CMD_COST = 2'd0,
    CMD_TOUR = 2'd1,
    CMD_RUN  = 2'd2,
    CMD_READ = 2'd3
  } cmd_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_WR, ST_RD, ST_RD_OUT,
    ST_I0, ST_I1, ST_I2, ST_J0, ST_J1,
    ST_C0, ST_C1, ST_C2,
    ST_R0, ST_R1, ST_R2,
    ST_S0, ST_S1, ST_S2, ST_S3, ST_S4, ST_S5,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    TA_POS, TA_I, TA_I1, TA_JN, TA_LO, TA_P
  } tour_ra_e;

  typedef enum logic [1:0] {
    TW_IN, TW_LO, TW_HI
  } tour_w_e;

  typedef enum logic [1:0] {
    CR_OLD, CR_NEW, CR_SUM
  } cost_r_e;

  typedef enum logic [1:0] {
    OK_NONE, OK_READ, OK_RUN
  } out_kind_e;

  typedef struct packed {
    logic      latch_in;
    logic      init_run;
    logic      ld_ti;
    logic      ld_ti1;
    logic      init_j;
    logic      ld_tjn;
    logic      ld_old;
    logic      set_move;
    logic      next_j;
    logic      next_i;
    logic      init_rev;
    logic      ld_tmp;
    logic      next_rev;
    logic      init_sum;
    logic      ld_prev;
    logic      inc_p;
    logic      ld_cur;
    logic      acc_sum;
    tour_ra_e  tour_ra;
    logic      tour_we;
    tour_w_e   tour_w;
    logic      cost_we;
    cost_r_e   cost_r;
    logic      out_stb;
    out_kind_e out_kind;
  } dp_cmd_t;

  typedef struct packed {
    logic improve;
    logic j_last;
    logic i_last;
    logic rev_done;
    logic sum_last;
  } dp_status_t;

endpackage

[sv/two_opt_first_improvement.sv]
// Top level of the 2-opt first-improvement block: controller plus datapath.
//
// Usage: an item is taken when start_i is high and busy_o is low. cmd_i picks
// the operation: write a cost entry, write a tour position, run one 2-opt
// move, or read a tour position. Each item gives one result, shown on the
// result ports for one cycle with done_o high; the receiver cannot stall it.
// num_vertices_we_i writes num_vertices_i; the user must write it only while
// the block is idle, as the block itself does not enforce this.
// The next item can be taken in the cycle that shows the result.
// A run scans pairs; each pair check makes four cost reads through the two
// read ports of the cost memory. A move swaps tour entries pair by pair.
// The closing cost sum makes one tour read and one cost read per edge.
// Reset sets num_vertices to 64 and the block idle; the cost and tour
// memories are not cleared and must be loaded before a run.
module two_opt_first_improvement #(
  parameter int unsigned MAX_VERTICES = topt_pkg::MAX_VERTICES_DEF,
  parameter int unsigned COST_BITS    = topt_pkg::COST_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  cmd_i,
  input  logic [5:0]  from_vertex_i,
  input  logic [5:0]  to_vertex_i,
  input  logic [31:0] edge_cost_i,
  input  logic [5:0]  position_i,
  input  logic [5:0]  vertex_id_i,
  input  logic        num_vertices_we_i,
  input  logic [6:0]  num_vertices_i,
  output logic        done_o,
  output logic        improved_o,
  output logic [5:0]  first_cut_o,
  output logic [5:0]  second_cut_o,
  output logic [37:0] total_cost_o,
  output logic [5:0]  vertex_out_o
);

  topt_pkg::dp_cmd_t    dp_cmd;
  topt_pkg::dp_status_t dp_status;

  topt_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .cmd_i    (cmd_i),
    .status_i (dp_status),
    .cmd_o    (dp_cmd),
    .busy_o   (busy_o)
  );

  topt_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .COST_BITS    (COST_BITS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .from_vertex_i     (from_vertex_i),
    .to_vertex_i       (to_vertex_i),
    .edge_cost_i       (edge_cost_i),
    .position_i        (position_i),
    .vertex_id_i       (vertex_id_i),
    .num_vertices_we_i (num_vertices_we_i),
    .num_vertices_i    (num_vertices_i),
    .cmd_i             (dp_cmd),
    .status_o          (dp_status),
    .done_o            (done_o),
    .improved_o        (improved_o),
    .first_cut_o       (first_cut_o),
    .second_cut_o      (second_cut_o),
    .total_cost_o      (total_cost_o),
    .vertex_out_o      (vertex_out_o)
  );

endmodule

[sv/topt_ram.sv]
// Generic RAM: one write port, two read ports with registered read data.
module topt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] ra_addr_i,
  output logic [WIDTH-1:0]                      ra_data_o,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rb_addr_i,
  output logic [WIDTH-1:0]                      rb_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write one entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Register both reads
  always_ff @(posedge clk_i) begin
    ra_data_o <= mem_q[ra_addr_i];
    rb_data_o <= mem_q[rb_addr_i];
  end

endmodule

[sv/topt_ctrl.sv]
// Controller state machine: sequences writes, reads, the pair scan, reversal and cost sum.
module topt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [1:0]          cmd_i,
  input  topt_pkg::dp_status_t status_i,
  output topt_pkg::dp_cmd_t    cmd_o,
  output logic                busy_o
);

  topt_pkg::state_e state_q, state_d;
  topt_pkg::cmd_e   op_q, op_d;

  // Hold state and latched command
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= topt_pkg::ST_IDLE;
      op_q    <= topt_pkg::CMD_COST;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    case (state_q)
      topt_pkg::ST_IDLE: begin
        if (start_i) begin
          op_d = topt_pkg::cmd_e'(cmd_i);
          case (topt_pkg::cmd_e'(cmd_i))
            topt_pkg::CMD_RUN:  state_d = topt_pkg::ST_I0;
            topt_pkg::CMD_READ: state_d = topt_pkg::ST_RD;
            default:            state_d = topt_pkg::ST_WR;
          endcase
        end
      end
      topt_pkg::ST_WR:     state_d = topt_pkg::ST_IDLE;
      topt_pkg::ST_RD:     state_d = topt_pkg::ST_RD_OUT;
      topt_pkg::ST_RD_OUT: state_d = topt_pkg::ST_IDLE;
      topt_pkg::ST_I0:     state_d = topt_pkg::ST_I1;
      topt_pkg::ST_I1:     state_d = topt_pkg::ST_I2;
      topt_pkg::ST_I2:     state_d = topt_pkg::ST_J0;
      topt_pkg::ST_J0:     state_d = topt_pkg::ST_J1;
      topt_pkg::ST_J1:     state_d = topt_pkg::ST_C0;
      topt_pkg::ST_C0:     state_d = topt_pkg::ST_C1;
      topt_pkg::ST_C1:     state_d = topt_pkg::ST_C2;
      topt_pkg::ST_C2: begin
        if (status_i.improve) begin
          state_d = topt_pkg::ST_R0;
        end else if (!status_i.j_last) begin
          state_d = topt_pkg::ST_J0;
        end else if (status_i.i_last) begin
          state_d = topt_pkg::ST_S0;
        end else begin
          state_d = topt_pkg::ST_I0;
        end
      end
      topt_pkg::ST_R0: begin
        state_d = status_i.rev_done ? topt_pkg::ST_S0 : topt_pkg::ST_R1;
      end
      topt_pkg::ST_R1: state_d = topt_pkg::ST_R2;
      topt_pkg::ST_R2: state_d = topt_pkg::ST_R0;
      topt_pkg::ST_S0: state_d = topt_pkg::ST_S1;
      topt_pkg::ST_S1: state_d = topt_pkg::ST_S2;
      topt_pkg::ST_S2: state_d = topt_pkg::ST_S3;
      topt_pkg::ST_S3: state_d = topt_pkg::ST_S4;
      topt_pkg::ST_S4: state_d = topt_pkg::ST_S5;
      topt_pkg::ST_S5: begin
        state_d = status_i.sum_last ? topt_pkg::ST_DONE : topt_pkg::ST_S2;
      end
      topt_pkg::ST_DONE: state_d = topt_pkg::ST_IDLE;
      default:           state_d = topt_pkg::ST_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd_o          = '0;
    cmd_o.tour_ra  = topt_pkg::TA_POS;
    cmd_o.tour_w   = topt_pkg::TW_IN;
    cmd_o.cost_r   = topt_pkg::CR_OLD;
    cmd_o.out_kind = topt_pkg::OK_NONE;
    case (state_q)
      topt_pkg::ST_IDLE: begin
        cmd_o.latch_in = start_i;
        cmd_o.init_run = start_i;
      end
      topt_pkg::ST_WR: begin
        cmd_o.cost_we = (op_q == topt_pkg::CMD_COST);
        cmd_o.tour_we = (op_q == topt_pkg::CMD_TOUR);
        cmd_o.out_stb = 1'b1;
      end
      topt_pkg::ST_RD: cmd_o.tour_ra = topt_pkg::TA_POS;
      topt_pkg::ST_RD_OUT: begin
        cmd_o.out_stb  = 1'b1;
        cmd_o.out_kind = topt_pkg::OK_READ;
      end
      topt_pkg::ST_I0: cmd_o.tour_ra = topt_pkg::TA_I;
      topt_pkg::ST_I1: begin
        cmd_o.ld_ti   = 1'b1;
        cmd_o.tour_ra = topt_pkg::TA_I1;
      end
      topt_pkg::ST_I2: begin
        cmd_o.ld_ti1 = 1'b1;
        cmd_o.init_j = 1'b1;
      end
      topt_pkg::ST_J0: cmd_o.tour_ra = topt_pkg::TA_JN;
      topt_pkg::ST_J1: cmd_o.ld_tjn = 1'b1;
      topt_pkg::ST_C0: cmd_o.cost_r = topt_pkg::CR_OLD;
      topt_pkg::ST_C1: begin
        cmd_o.ld_old = 1'b1;
        cmd_o.cost_r = topt_pkg::CR_NEW;
      end
      topt_pkg::ST_C2: begin
        if (status_i.improve) begin
          cmd_o.set_move = 1'b1;
          cmd_o.init_rev = 1'b1;
        end else if (!status_i.j_last) begin
          cmd_o.next_j = 1'b1;
        end else if (status_i.i_last) begin
          cmd_o.init_sum = 1'b1;
        end else begin
          cmd_o.next_i = 1'b1;
        end
      end
      topt_pkg::ST_R0: begin
        cmd_o.tour_ra  = topt_pkg::TA_LO;
        cmd_o.init_sum = status_i.rev_done;
      end
      topt_pkg::ST_R1: begin
        cmd_o.ld_tmp  = 1'b1;
        cmd_o.tour_we = 1'b1;
        cmd_o.tour_w  = topt_pkg::TW_LO;
      end
      topt_pkg::ST_R2: begin
        cmd_o.tour_we  = 1'b1;
        cmd_o.tour_w   = topt_pkg::TW_HI;
        cmd_o.next_rev = 1'b1;
      end
      topt_pkg::ST_S0: cmd_o.tour_ra = topt_pkg::TA_P;
      topt_pkg::ST_S1: begin
        cmd_o.ld_prev = 1'b1;
        cmd_o.inc_p   = 1'b1;
      end
      topt_pkg::ST_S2: cmd_o.tour_ra = topt_pkg::TA_P;
      topt_pkg::ST_S3: cmd_o.ld_cur = 1'b1;
      topt_pkg::ST_S4: cmd_o.cost_r = topt_pkg::CR_SUM;
      topt_pkg::ST_S5: begin
        cmd_o.acc_sum = 1'b1;
        cmd_o.inc_p   = !status_i.sum_last;
      end
      topt_pkg::ST_DONE: begin
        cmd_o.out_stb  = 1'b1;
        cmd_o.out_kind = topt_pkg::OK_RUN;
      end
      default: cmd_o.out_kind = topt_pkg::OK_NONE;
    endcase
  end

  assign busy_o = (state_q != topt_pkg::ST_IDLE);

endmodule

[sv/topt_datapath.sv]
// Datapath: cost and tour memories, scan counters, pair sums and result registers.
module topt_datapath #(
  parameter int unsigned MAX_VERTICES = topt_pkg::MAX_VERTICES_DEF,
  parameter int unsigned COST_BITS    = topt_pkg::COST_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [5:0]            from_vertex_i,
  input  logic [5:0]            to_vertex_i,
  input  logic [31:0]           edge_cost_i,
  input  logic [5:0]            position_i,
  input  logic [5:0]            vertex_id_i,
  input  logic                  num_vertices_we_i,
  input  logic [6:0]            num_vertices_i,
  input  topt_pkg::dp_cmd_t      cmd_i,
  output topt_pkg::dp_status_t   status_o,
  output logic                  done_o,
  output logic                  improved_o,
  output logic [5:0]            first_cut_o,
  output logic [5:0]            second_cut_o,
  output logic [37:0]           total_cost_o,
  output logic [5:0]            vertex_out_o
);

  localparam int unsigned TW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned PW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned CD = MAX_VERTICES * MAX_VERTICES;
  localparam int unsigned AW = $clog2(CD);
  localparam int unsigned SW = COST_BITS + PW;
  localparam int unsigned VW = topt_pkg::VID_W;

  // Latched item and configuration
  logic [5:0]  from_q, to_q, pos_q, vid_q;
  logic [31:0] cost_q;
  logic [6:0]  num_q;

  // Scan state
  logic [PW-1:0] i_q, j_q, lo_q, hi_q, p_q;
  logic [VW-1:0] ti_q, ti1_q, tj_q, tjn_q, tmp_q, prev_q, cur_q;
  logic [COST_BITS:0] old_q;
  logic [SW-1:0] sum_q;
  logic          mv_q;
  logic [PW-1:0] mi_q, mj_q;
  logic          oka_q, okb_q;

  // Result registers
  logic        done_q, improved_q;
  logic [5:0]  fc_q, sc_q, vout_q;
  logic [37:0] total_q;

  logic [PW-1:0] n_w, jn_w, i1_w, pa_w;
  logic          pos_ok;

  // Memory ports
  logic [TW-1:0]        t_waddr, t_raddr;
  logic [VW-1:0]        t_wdata, t_ra, t_rb;
  logic                 t_we;
  logic [AW-1:0]        c_waddr, c_aaddr, c_baddr;
  logic [COST_BITS-1:0] c_ra, c_rb, cost_a, cost_b;
  logic                 c_we;
  logic [VW-1:0]        ra_row, ra_col, rb_row, rb_col;
  logic                 oka, okb;
  logic [COST_BITS:0]   pair_w;

  // Clamp the city count into range
  always_comb begin
    if (num_q < topt_pkg::NUM_VERTICES_MIN) begin
      n_w = PW'(topt_pkg::NUM_VERTICES_MIN);
    end else if (int'(num_q) > int'(MAX_VERTICES)) begin
      n_w = PW'(MAX_VERTICES);
    end else begin
      n_w = PW'(num_q);
    end
  end

  assign i1_w   = i_q + PW'(1);
  assign jn_w   = (j_q + PW'(1) == n_w) ? '0 : j_q + PW'(1);
  assign pa_w   = (p_q == n_w) ? '0 : p_q;
  assign pos_ok = int'(pos_q) < int'(MAX_VERTICES);

  // Select tour read address
  always_comb begin
    case (cmd_i.tour_ra)
      topt_pkg::TA_POS: t_raddr = TW'(pos_q);
      topt_pkg::TA_I:   t_raddr = i_q[TW-1:0];
      topt_pkg::TA_I1:  t_raddr = i1_w[TW-1:0];
      topt_pkg::TA_JN:  t_raddr = jn_w[TW-1:0];
      topt_pkg::TA_LO:  t_raddr = lo_q[TW-1:0];
      topt_pkg::TA_P:   t_raddr = pa_w[TW-1:0];
      default:          t_raddr = '0;
    endcase
  end

  // Select tour write
  always_comb begin
    case (cmd_i.tour_w)
      topt_pkg::TW_LO: begin
        t_waddr = lo_q[TW-1:0];
        t_wdata = t_rb;
        t_we    = cmd_i.tour_we;
      end
      topt_pkg::TW_HI: begin
        t_waddr = hi_q[TW-1:0];
        t_wdata = tmp_q;
        t_we    = cmd_i.tour_we;
      end
      default: begin
        t_waddr = TW'(pos_q);
        t_wdata = vid_q;
        t_we    = cmd_i.tour_we && pos_ok;
      end
    endcase
  end

  // Select cost read vertices
  always_comb begin
    case (cmd_i.cost_r)
      topt_pkg::CR_NEW: begin
        ra_row = ti_q;  ra_col = tj_q;
        rb_row = ti1_q; rb_col = tjn_q;
      end
      topt_pkg::CR_SUM: begin
        ra_row = prev_q; ra_col = cur_q;
        rb_row = prev_q; rb_col = cur_q;
      end
      default: begin
        ra_row = ti_q; ra_col = ti1_q;
        rb_row = tj_q; rb_col = tjn_q;
      end
    endcase
  end

  assign oka = (int'(ra_row) < int'(MAX_VERTICES)) && (int'(ra_col) < int'(MAX_VERTICES));
  assign okb = (int'(rb_row) < int'(MAX_VERTICES)) && (int'(rb_col) < int'(MAX_VERTICES));
  assign c_aaddr = AW'(ra_row) * AW'(MAX_VERTICES) + AW'(ra_col);
  assign c_baddr = AW'(rb_row) * AW'(MAX_VERTICES) + AW'(rb_col);
  assign c_waddr = AW'(from_q) * AW'(MAX_VERTICES) + AW'(to_q);
  assign c_we    = cmd_i.cost_we && (int'(from_q) < int'(MAX_VERTICES))
                   && (int'(to_q) < int'(MAX_VERTICES));

  // Cities beyond the matrix read as zero cost
  assign cost_a = oka_q ? c_ra : '0;
  assign cost_b = okb_q ? c_rb : '0;
  assign pair_w = {1'b0, cost_a} + {1'b0, cost_b};

  topt_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_tour_ram (
    .clk_i     (clk_i),
    .we_i      (t_we),
    .waddr_i   (t_waddr),
    .wdata_i   (t_wdata),
    .ra_addr_i (t_raddr),
    .ra_data_o (t_ra),
    .rb_addr_i (hi_q[TW-1:0]),
    .rb_data_o (t_rb)
  );

  topt_ram #(.WIDTH(COST_BITS), .DEPTH(CD)) u_cost_ram (
    .clk_i     (clk_i),
    .we_i      (c_we),
    .waddr_i   (c_waddr),
    .wdata_i   (COST_BITS'(cost_q)),
    .ra_addr_i (c_aaddr),
    .ra_data_o (c_ra),
    .rb_addr_i (c_baddr),
    .rb_data_o (c_rb)
  );

  // Hold the configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q <= topt_pkg::NUM_VERTICES_RESET;
    end else if (num_vertices_we_i) begin
      num_q <= num_vertices_i;
    end
  end

  // Latch the item and advance scan registers
  always_ff @(posedge clk_i) begin
    oka_q <= oka;
    okb_q <= okb;
    if (cmd_i.latch_in) begin
      from_q <= from_vertex_i;
      to_q   <= to_vertex_i;
      cost_q <= edge_cost_i;
      pos_q  <= position_i;
      vid_q  <= vertex_id_i;
    end
    if (cmd_i.init_run) begin
      i_q  <= '0;
      mv_q <= 1'b0;
      mi_q <= '0;
      mj_q <= '0;
    end
    if (cmd_i.next_i) i_q <= i1_w;
    if (cmd_i.ld_ti)  ti_q <= t_ra;
    if (cmd_i.ld_ti1) ti1_q <= t_ra;
    if (cmd_i.init_j) begin
      j_q  <= i1_w;
      tj_q <= t_ra;
    end
    if (cmd_i.ld_tjn) tjn_q <= t_ra;
    if (cmd_i.next_j) begin
      j_q  <= j_q + PW'(1);
      tj_q <= tjn_q;
    end
    if (cmd_i.ld_old) old_q <= pair_w;
    if (cmd_i.set_move) begin
      mv_q <= 1'b1;
      mi_q <= i_q;
      mj_q <= j_q;
    end
    if (cmd_i.init_rev) begin
      lo_q <= i1_w;
      hi_q <= j_q;
    end
    if (cmd_i.ld_tmp) tmp_q <= t_ra;
    if (cmd_i.next_rev) begin
      lo_q <= lo_q + PW'(1);
      hi_q <= hi_q - PW'(1);
    end
    if (cmd_i.init_sum) begin
      p_q   <= '0;
      sum_q <= '0;
    end
    if (cmd_i.ld_prev) prev_q <= t_ra;
    if (cmd_i.inc_p)   p_q <= p_q + PW'(1);
    if (cmd_i.ld_cur)  cur_q <= t_ra;
    if (cmd_i.acc_sum) begin
      sum_q  <= sum_q + SW'(cost_a);
      prev_q <= cur_q;
    end
  end

  // Strobe the result for one cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.out_stb;
    end
  end

  // Load the result fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_stb) begin
      case (cmd_i.out_kind)
        topt_pkg::OK_READ: begin
          improved_q <= 1'b0;
          fc_q       <= '0;
          sc_q       <= '0;
          total_q    <= '0;
          vout_q     <= pos_ok ? t_ra : '0;
        end
        topt_pkg::OK_RUN: begin
          improved_q <= mv_q;
          fc_q       <= 6'(mi_q);
          sc_q       <= 6'(mj_q);
          total_q    <= 38'(sum_q);
          vout_q     <= '0;
        end
        default: begin
          improved_q <= 1'b0;
          fc_q       <= '0;
          sc_q       <= '0;
          total_q    <= '0;
          vout_q     <= '0;
        end
      endcase
    end
  end

  assign status_o.improve  = pair_w < old_q;
  assign status_o.j_last   = (j_q + PW'(1) == n_w);
  assign status_o.i_last   = (i_q + PW'(2) == n_w);
  assign status_o.rev_done = (lo_q >= hi_q);
  assign status_o.sum_last = (p_q == n_w);

  assign done_o       = done_q;
  assign improved_o   = improved_q;
  assign first_cut_o  = fc_q;
  assign second_cut_o = sc_q;
  assign total_cost_o = total_q;
  assign vertex_out_o = vout_q;

endmodule

[sv/topt_checker.sv]
// Port-level checker for the 2-opt block and its bind to the top level.
module topt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        done_o,
  input logic        improved_o,
  input logic [5:0]  first_cut_o,
  input logic [5:0]  second_cut_o
);

  // An accepted item makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("item accepted but block not busy");

  // A result is shown only once the block is idle again
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result shown while busy");

  // Going idle always delivers the result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> done_o)
    else $error("busy dropped without a result");

  // A move has its cuts in order; without a move both cuts are zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && improved_o |-> first_cut_o < second_cut_o)
    else $error("applied move with cuts out of order");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !improved_o |-> first_cut_o == 6'd0 && second_cut_o == 6'd0)
    else $error("cuts nonzero without a move");

endmodule

bind two_opt_first_improvement topt_checker u_topt_checker (.*);

[verif/tb.sv]
// Testbench for the 2-opt first-improvement block: queued items, clocked driver and monitor.
module tb;

  typedef struct {
    topt_pkg::cmd_e cmd;
    logic [5:0]     from_v;
    logic [5:0]     to_v;
    logic [31:0]    cost;
    logic [5:0]     pos;
    logic [5:0]     vid;
  } tsp_item_t;

  typedef struct {
    logic        improved;
    logic [5:0]  cut_i;
    logic [5:0]  cut_j;
    logic [37:0] total;
    logic [5:0]  city;
  } tsp_result_t;

  localparam int unsigned CYCLE_LIMIT = 3000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic [1:0]  cmd_i = topt_pkg::CMD_COST;
  logic [5:0]  from_vertex_i = '0;
  logic [5:0]  to_vertex_i = '0;
  logic [31:0] edge_cost_i = '0;
  logic [5:0]  position_i = '0;
  logic [5:0]  vertex_id_i = '0;
  logic        num_vertices_we_i = 1'b0;
  logic [6:0]  num_vertices_i = topt_pkg::NUM_VERTICES_RESET;
  logic        busy_o, done_o, improved_o;
  logic [5:0]  first_cut_o, second_cut_o, vertex_out_o;
  logic [37:0] total_cost_o;

  // Shadow copy of the block's state
  logic [31:0] cost_tab [0:4095];
  logic [5:0]  tour_tab [0:63];
  logic [6:0]  count_reg = topt_pkg::NUM_VERTICES_RESET;

  tsp_item_t   pending_items[$];
  tsp_result_t expected_results[$];
  tsp_item_t   on_port;
  int unsigned n_queued = 0, n_taken = 0, n_checked = 0, n_errors = 0;
  int unsigned n_runs = 0, n_moves = 0, idle_pct = 0;
  int unsigned cycles = 0;

  two_opt_first_improvement u_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .cmd_i, .from_vertex_i, .to_vertex_i,
    .edge_cost_i, .position_i, .vertex_id_i, .num_vertices_we_i,
    .num_vertices_i, .done_o, .improved_o, .first_cut_o, .second_cut_o,
    .total_cost_o, .vertex_out_o
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [37:0] link_cost(logic [5:0] a, logic [5:0] b);
    return {6'd0, cost_tab[{a, b}]};
  endfunction

  // Tours use only three cities, so only their cost entries are ever read
  function automatic int pick_city(int k);
    return (k % 3 == 2) ? 63 : k % 3;
  endfunction

  // Compute the result of one item and update the shadow state
  function automatic tsp_result_t apply_item(tsp_item_t it);
    tsp_result_t r;
    int unsigned n, jn, lo, hi;
    logic [37:0] old_pair, new_pair, sum;
    logic [5:0]  t;
    bit          found;
    r = '{default: '0};
    found = 0;
    case (it.cmd)
      topt_pkg::CMD_COST: cost_tab[{it.from_v, it.to_v}] = it.cost;
      topt_pkg::CMD_TOUR: tour_tab[it.pos] = it.vid;
      topt_pkg::CMD_READ: r.city = tour_tab[it.pos];
      default: begin
        n = count_reg < topt_pkg::NUM_VERTICES_MIN ? topt_pkg::NUM_VERTICES_MIN :
            (count_reg > topt_pkg::MAX_VERTICES_DEF ? topt_pkg::MAX_VERTICES_DEF
                                                    : count_reg);
        for (int i = 0; i + 1 < n && !found; i++) begin
          for (int j = i + 1; j < n && !found; j++) begin
            jn = (j + 1 == n) ? 0 : j + 1;
            old_pair = link_cost(tour_tab[i], tour_tab[i+1]) +
                       link_cost(tour_tab[j], tour_tab[jn]);
            new_pair = link_cost(tour_tab[i], tour_tab[j]) +
                       link_cost(tour_tab[i+1], tour_tab[jn]);
            if (new_pair < old_pair) begin
              lo = i + 1;
              hi = j;
              while (lo < hi) begin
                t = tour_tab[lo];
                tour_tab[lo] = tour_tab[hi];
                tour_tab[hi] = t;
                lo++;
                hi--;
              end
              r.improved = 1'b1;
              r.cut_i = i[5:0];
              r.cut_j = j[5:0];
              found = 1;
            end
          end
        end
        sum = '0;
        for (int p = 0; p + 1 < n; p++) sum += link_cost(tour_tab[p], tour_tab[p+1]);
        sum += link_cost(tour_tab[n-1], tour_tab[0]);
        r.total = sum;
      end
    endcase
    return r;
  endfunction

  // Drive items from the pending queue; predict each one as it is taken
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        expected_results = {expected_results, apply_item(on_port)};
        n_taken++;
        if (on_port.cmd == topt_pkg::CMD_RUN) n_runs++;
      end
      if (!(start_i && busy_o)) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
          on_port = pending_items.pop_front();
          start_i <= 1'b1;
          cmd_i <= on_port.cmd;
          from_vertex_i <= on_port.from_v;
          to_vertex_i <= on_port.to_v;
          edge_cost_i <= on_port.cost;
          position_i <= on_port.pos;
          vertex_id_i <= on_port.vid;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // Check each result against the oldest expectation
  always @(posedge clk_i) begin
    tsp_result_t e;
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("ERROR: result with no item outstanding");
      end else begin
        e = expected_results.pop_front();
        n_checked++;
        if (improved_o) n_moves++;
        if (improved_o !== e.improved || first_cut_o !== e.cut_i ||
            second_cut_o !== e.cut_j || total_cost_o !== e.total ||
            vertex_out_o !== e.city) begin
          n_errors++;
          if (n_errors <= 10)
            $display({"ERROR: result %0d exp imp=%0d i=%0d j=%0d cost=%0d v=%0d",
                      " got imp=%0d i=%0d j=%0d cost=%0d v=%0d"},
                     n_checked, e.improved, e.cut_i, e.cut_j, e.total, e.city,
                     improved_o, first_cut_o, second_cut_o, total_cost_o, vertex_out_o);
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic add_item(topt_pkg::cmd_e c, int f, int t, logic [31:0] w, int p, int v);
    tsp_item_t it;
    it.cmd = c;
    it.from_v = f[5:0];
    it.to_v = t[5:0];
    it.cost = w;
    it.pos = p[5:0];
    it.vid = v[5:0];
    pending_items = {pending_items, it};
    n_queued++;
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (n_taken != n_queued || n_checked != n_taken);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_count(logic [6:0] v);
    @(posedge clk_i);
    num_vertices_we_i <= 1'b1;
    num_vertices_i <= v;
    count_reg = v;
    @(posedge clk_i);
    num_vertices_we_i <= 1'b0;
  endtask

  // Random items; the caller picks a lower run share when the tour is long
  task automatic add_random(int cnt, int run_pct);
    int pick, k;
    topt_pkg::cmd_e c;
    for (int n = 0; n < cnt; n++) begin
      pick = $urandom_range(99);
      k = $urandom_range(3);
      if (pick < run_pct) c = topt_pkg::CMD_RUN;
      else if (k == 0) c = topt_pkg::CMD_READ;
      else if (k == 1) c = topt_pkg::CMD_TOUR;
      else c = topt_pkg::CMD_COST;
      add_item(c, $urandom_range(63), $urandom_range(63),
               $urandom_range(3) == 0 ? 32'hFFFF_FFFF : $urandom(),
               $urandom_range(63), pick_city($urandom_range(2)));
    end
  endtask

  initial begin
    logic [6:0] counts [9];
    int         pcts [9];
    counts = '{7'd3, 7'd0, 7'd1, 7'd2, 7'd5, 7'd8, 7'd127, 7'd12, 7'd64};
    pcts = '{0, 70, 0, 70, 26, 0, 70, 0, 26};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Load every tour position and every cost entry among the tour's cities
    for (int p = 0; p < 64; p++) add_item(topt_pkg::CMD_TOUR, 0, 0, 0, p, pick_city(p));
    for (int a = 0; a < 3; a++)
      for (int b = 0; b < 3; b++)
        add_item(topt_pkg::CMD_COST, pick_city(a), pick_city(b), $urandom_range(1000), 0, 0);
    wait_idle();

    // Directed: field extremes, each command, a full-size run at reset count
    add_item(topt_pkg::CMD_COST, 0, 63, 32'hFFFF_FFFF, 0, 0);
    add_item(topt_pkg::CMD_COST, 63, 0, 32'h0, 63, 63);
    add_item(topt_pkg::CMD_READ, 63, 63, 32'hFFFF_FFFF, 0, 63);
    add_item(topt_pkg::CMD_READ, 0, 0, 0, 63, 0);
    add_item(topt_pkg::CMD_TOUR, 63, 63, 32'hFFFF_FFFF, 63, 63);
    add_item(topt_pkg::CMD_TOUR, 0, 0, 0, 63, 63);
    add_item(topt_pkg::CMD_RUN, 0, 0, 0, 0, 0);
    add_item(topt_pkg::CMD_READ, 0, 0, 0, 1, 0);
    wait_idle();

    // Small tour with a strong improving move, then one with none
    set_count(7'd4);
    add_item(topt_pkg::CMD_COST, 0, 1, 32'hFFFF_FFFF, 0, 0);
    add_item(topt_pkg::CMD_COST, 1, 63, 32'hFFFF_FFFF, 0, 0);
    add_item(topt_pkg::CMD_RUN, 63, 63, 32'hFFFF_FFFF, 63, 63);
    add_item(topt_pkg::CMD_RUN, 0, 0, 0, 0, 0);
    add_item(topt_pkg::CMD_RUN, 0, 0, 0, 0, 0);
    add_item(topt_pkg::CMD_READ, 0, 0, 0, 1, 0);
    add_item(topt_pkg::CMD_READ, 0, 0, 0, 2, 0);
    wait_idle();

    // Random phases over several tour lengths and idle settings
    for (int ph = 0; ph < 9; ph++) begin
      set_count(counts[ph]);
      idle_pct = pcts[ph];
      add_random(3, (counts[ph] > 16) ? 10 : 30);
      wait_idle();
    end
    idle_pct = 0;

    repeat (20) @(posedge clk_i);
    $display("covered %0d items, %0d runs, %0d applied moves, over 11 tour-length settings",
             n_taken, n_runs, n_moves);
    $display("%0d results checked, %0d mismatches", n_checked, n_errors);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
